// File: rtl/core/tslm_pkg.sv
// shared constants, command codes and control/status structs of the label merge block
// no dependencies
`timescale 1ns / 1ps

package tslm_pkg;

	localparam int DEF_MAX_LABELS = 8;
	localparam int DEF_KEY_BITS   = 16;
	localparam int DEF_POS_BITS   = 31;

	localparam int CMD_W      = 2;
	localparam int LIMIT_W    = 4;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 4;

	localparam logic [CMD_W-1:0] CMD_PUSH_ACC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_NB  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MERGE    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

	localparam logic [CFG_ADDR_W-1:0] REG_LABEL_LIMIT = 4'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TIE_MODE    = 4'd1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

	typedef struct packed {
		logic push_acc;
		logic push_nb;
		logic merge_step;
		logic merge_finish;
		logic read_load;
	} tslm_ctl_t;

	typedef struct packed {
		logic merge_done;
		logic read_last;
		logic out_free;
	} tslm_stat_t;

endpackage

// File: rtl/core/tslm_in_if.sv
// command channel: valid/ready with command and pushed entry
// depends on tslm_pkg
`timescale 1ns / 1ps

interface tslm_in_if #(
	parameter int KEY_BITS = tslm_pkg::DEF_KEY_BITS,
	parameter int POS_BITS = tslm_pkg::DEF_POS_BITS
);
	logic                         valid;
	logic                         ready;
	logic [tslm_pkg::CMD_W-1:0]   command;
	logic [KEY_BITS-1:0]          entry_key;
	logic [POS_BITS-1:0]          entry_position;

	modport source (output valid, command, entry_key, entry_position, input ready);
	modport sink   (input valid, command, entry_key, entry_position, output ready);
endinterface

// File: rtl/core/tslm_out_if.sv
// result channel: valid/ready with one read-out accumulator entry
// depends on tslm_pkg
`timescale 1ns / 1ps

interface tslm_out_if #(
	parameter int KEY_BITS = tslm_pkg::DEF_KEY_BITS,
	parameter int POS_BITS = tslm_pkg::DEF_POS_BITS
);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] out_key;
	logic [POS_BITS-1:0] out_position;
	logic                out_empty;
	logic                out_last;
	logic                overflow;

	modport source (output valid, out_key, out_position, out_empty, out_last, overflow,
		input ready);
	modport sink   (input valid, out_key, out_position, out_empty, out_last, overflow,
		output ready);
endinterface

// File: rtl/core/tslm_cfg_if.sv
// configuration write channel: valid/ready with register index and data
// depends on tslm_pkg
`timescale 1ns / 1ps

interface tslm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tslm_pkg::CFG_ADDR_W-1:0]   index;
	logic [tslm_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/topk_sorted_label_merge.sv
// Bounded top-k merge of two sorted (key, position) label lists. A push of either list
// is taken and written in its accepting cycle. A merge keeps k entries, k being at most
// label_limit. After the accepting cycle, the walk takes one step per kept entry: it
// reads one entry of each list from its ram port, compares the keys and writes one
// merged entry into the idle accumulator bank. A last step swaps the banks. A read out
// gives, after its accepting cycle, one item per cycle from the accumulator read port
// (a single empty item for an empty accumulator), but stalls in every cycle in which
// the result side holds off while the output register is full.
// Configuration writes are taken in any cycle.
// depends on tslm_pkg, tslm_in_if, tslm_out_if, tslm_cfg_if, tslm_ctrl, tslm_dp
`timescale 1ns / 1ps

module topk_sorted_label_merge #(
	parameter int MAX_LABELS = tslm_pkg::DEF_MAX_LABELS,
	parameter int KEY_BITS   = tslm_pkg::DEF_KEY_BITS,
	parameter int POS_BITS   = tslm_pkg::DEF_POS_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	tslm_in_if.sink     req,
	tslm_out_if.source  rsp,
	tslm_cfg_if.sink    cfg
);
	import tslm_pkg::*;

	tslm_ctl_t  ctl;
	tslm_stat_t stat;

	tslm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.ctl    (ctl)
	);

	tslm_dp #(
		.MAX_LABELS (MAX_LABELS),
		.KEY_BITS   (KEY_BITS),
		.POS_BITS   (POS_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.push_key (req.entry_key),
		.push_pos (req.entry_position),
		.cfg      (cfg),
		.rsp      (rsp)
	);

endmodule

// File: rtl/core/tslm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tslm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/tslm_ctrl.sv
// controller state machine: command decode, merge walk and read-out sequencing
// depends on tslm_pkg, tslm_in_if
`timescale 1ns / 1ps

module tslm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	tslm_in_if.sink              req,
	input  tslm_pkg::tslm_stat_t stat,
	output tslm_pkg::tslm_ctl_t  ctl
);
	import tslm_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MERGE = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.command)
						CMD_PUSH_ACC: ctl.push_acc = 1'b1;
						CMD_PUSH_NB:  ctl.push_nb  = 1'b1;
						CMD_MERGE:    state_d      = S_MERGE;
						default:      state_d      = S_READ;
					endcase
				end
			end
			S_MERGE: begin
				if (stat.merge_done) begin
					ctl.merge_finish = 1'b1;
					state_d          = S_IDLE;
				end else begin
					ctl.merge_step = 1'b1;
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					ctl.read_load = 1'b1;
					if (stat.read_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/tslm_dp.sv
// datapath: list rams, counts, merge compare/select, config registers, output register
// depends on tslm_pkg, tslm_ram, tslm_out_if, tslm_cfg_if
`timescale 1ns / 1ps

module tslm_dp #(
	parameter int MAX_LABELS = tslm_pkg::DEF_MAX_LABELS,
	parameter int KEY_BITS   = tslm_pkg::DEF_KEY_BITS,
	parameter int POS_BITS   = tslm_pkg::DEF_POS_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tslm_pkg::tslm_ctl_t  ctl,
	output tslm_pkg::tslm_stat_t stat,
	input  logic [KEY_BITS-1:0]  push_key,
	input  logic [POS_BITS-1:0]  push_pos,
	tslm_cfg_if.sink             cfg,
	tslm_out_if.source           rsp
);
	import tslm_pkg::*;

	localparam int CNT_W = $clog2(MAX_LABELS + 1);
	localparam int IDX_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int ENT_W = KEY_BITS + POS_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LABELS);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [LIMIT_W-1:0]  limit_q;
	logic                tie_q;
	logic [CNT_W-1:0]    acc_cnt_q;
	logic [CNT_W-1:0]    nb_cnt_q;
	logic                drop_q;
	logic                bank_q;
	logic [CNT_W-1:0]    a_q, b_q, n_q;
	logic [CNT_W-1:0]    a_d, b_d;
	logic [CNT_W-1:0]    limit_eff;

	logic                out_valid_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [POS_BITS-1:0] out_pos_q;
	logic                out_empty_q;
	logic                out_last_q;
	logic                out_ovf_q;

	logic [ENT_W-1:0]    acc_rd [2];
	logic [ENT_W-1:0]    nb_rd;
	logic [ENT_W-1:0]    cur_rd;
	logic [KEY_BITS-1:0] ka, kb;
	logic [POS_BITS-1:0] pa, pb, tie_pos;
	logic                a_end, b_end, take_a, take_b;
	logic [ENT_W-1:0]    merged;
	logic [ENT_W-1:0]    acc_wdata;
	logic [IDX_W-1:0]    acc_waddr;
	logic                acc_push_ok, nb_push_ok;
	logic                acc_we [2];
	logic                acc_empty;

	// limit saturates at list capacity
	always_comb begin
		if (int'(limit_q) > MAX_LABELS) begin
			limit_eff = CNT_MAX;
		end else begin
			limit_eff = CNT_W'(limit_q);
		end
	end

	assign cur_rd = bank_q ? acc_rd[1] : acc_rd[0];
	assign ka     = cur_rd[ENT_W-1:POS_BITS];
	assign pa     = cur_rd[POS_BITS-1:0];
	assign kb     = nb_rd[ENT_W-1:POS_BITS];
	assign pb     = nb_rd[POS_BITS-1:0];

	assign a_end  = (a_q == acc_cnt_q);
	assign b_end  = (b_q == nb_cnt_q);
	assign take_a = b_end || (!a_end && (ka < kb));
	assign take_b = !take_a && (a_end || (ka > kb));

	always_comb begin
		if (tie_q) begin
			tie_pos = (pa <= pb) ? pa : pb;
		end else begin
			tie_pos = (pa >= pb) ? pa : pb;
		end
		if (take_a) begin
			merged = {ka, pa};
		end else if (take_b) begin
			merged = {kb, pb};
		end else begin
			merged = {ka, tie_pos};
		end
	end

	assign acc_empty = (acc_cnt_q == '0);
	assign stat.merge_done = (a_end && b_end) || (n_q == limit_eff);
	assign stat.read_last  = acc_empty || ((a_q + CNT_ONE) == acc_cnt_q);
	assign stat.out_free   = !out_valid_q || rsp.ready;

	assign acc_push_ok = ctl.push_acc && (acc_cnt_q != CNT_MAX);
	assign nb_push_ok  = ctl.push_nb && (nb_cnt_q != CNT_MAX);

	// merge writes the idle bank, pushes write the live bank
	assign acc_wdata = ctl.merge_step ? merged : {push_key, push_pos};
	assign acc_waddr = ctl.merge_step ? n_q[IDX_W-1:0] : acc_cnt_q[IDX_W-1:0];
	assign acc_we[0] = (acc_push_ok && !bank_q) || (ctl.merge_step && bank_q);
	assign acc_we[1] = (acc_push_ok && bank_q) || (ctl.merge_step && !bank_q);

	// read pointers lead the ram address so read data follows the pointer
	always_comb begin
		a_d = a_q;
		b_d = b_q;
		if (ctl.merge_step) begin
			if (!take_b) begin
				a_d = a_q + CNT_ONE;
			end
			if (!take_a) begin
				b_d = b_q + CNT_ONE;
			end
		end else if (ctl.merge_finish) begin
			a_d = '0;
			b_d = '0;
		end else if (ctl.read_load) begin
			a_d = stat.read_last ? '0 : (a_q + CNT_ONE);
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_acc
		tslm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_LABELS)) u_acc_ram (
			.clk   (clk),
			.we    (acc_we[g]),
			.waddr (acc_waddr),
			.wdata (acc_wdata),
			.raddr (a_d[IDX_W-1:0]),
			.rdata (acc_rd[g])
		);
	end

	tslm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_LABELS)) u_nb_ram (
		.clk   (clk),
		.we    (nb_push_ok),
		.waddr (nb_cnt_q[IDX_W-1:0]),
		.wdata ({push_key, push_pos}),
		.raddr (b_d[IDX_W-1:0]),
		.rdata (nb_rd)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			tie_q       <= 1'b0;
			acc_cnt_q   <= '0;
			nb_cnt_q    <= '0;
			drop_q      <= 1'b0;
			bank_q      <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && (cfg.index == REG_LABEL_LIMIT)) begin
				limit_q <= cfg.data[LIMIT_W-1:0];
			end
			if (cfg.valid && (cfg.index == REG_TIE_MODE)) begin
				tie_q <= cfg.data[0];
			end
			a_q <= a_d;
			b_q <= b_d;
			if (ctl.push_acc) begin
				if (acc_push_ok) begin
					acc_cnt_q <= acc_cnt_q + CNT_ONE;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (ctl.push_nb) begin
				if (nb_push_ok) begin
					nb_cnt_q <= nb_cnt_q + CNT_ONE;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (ctl.merge_step) begin
				n_q <= n_q + CNT_ONE;
			end
			if (ctl.merge_finish) begin
				acc_cnt_q <= n_q;
				nb_cnt_q  <= '0;
				bank_q    <= ~bank_q;
				n_q       <= '0;
			end
			if (ctl.read_load) begin
				out_valid_q <= 1'b1;
				if (stat.read_last) begin
					acc_cnt_q <= '0;
					drop_q    <= 1'b0;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ctl.read_load) begin
			out_key_q   <= acc_empty ? '0 : ka;
			out_pos_q   <= acc_empty ? '0 : pa;
			out_empty_q <= acc_empty;
			out_last_q  <= stat.read_last;
			out_ovf_q   <= drop_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_key      = out_key_q;
	assign rsp.out_position = out_pos_q;
	assign rsp.out_empty    = out_empty_q;
	assign rsp.out_last     = out_last_q;
	assign rsp.overflow     = out_ovf_q;

endmodule
